[rtl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psp_pkg.sv]
// Types, codes and arithmetic helpers for the projectile slot pool.
package psp_pkg;

    localparam int IN_W   = 184;
    localparam int USER_W = 2;
    localparam int OUT_W  = 80;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_SPAWN  = 2'd0;
    localparam t_cmd CMD_UPDATE = 2'd1;
    localparam t_cmd CMD_SAMPLE = 2'd2;
    localparam t_cmd CMD_NOP    = 2'd3;

    localparam logic CFG_SPEED    = 1'b0;
    localparam logic CFG_LIFETIME = 1'b1;

    // squared raw length at or below this is a short direction
    localparam logic [63:0] MIN_LEN_SQ = 64'd42;
    localparam logic [16:0] AMT_ONE    = 17'd65536;
    localparam logic [30:0] RST_ONE    = 31'd65536;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_unit_req;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] life;
    } t_slot;

    // product / 65536, truncated toward zero
    function automatic logic signed [49:0] shr16_tz(input logic signed [65:0] p);
        logic signed [65:0] b;
        b = p + (p[65] ? 66'sd65535 : 66'sd0);
        return b[65:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/psp_rootdiv.sv]
// Shared bit-serial unit: 64-bit integer square root or 64/32 unsigned divide.
module psp_rootdiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psp_pkg::t_unit_req   i_req,
    input  logic [63:0]          i_opnd,
    input  logic [31:0]          i_dvsr,
    output logic                 o_done,
    output logic [63:0]          o_result
);

    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;   // sqrt: remainder; divide: dividend shifting into quotient
    logic [63:0] r_res;   // sqrt: root; divide: partial remainder
    logic [63:0] r_bit;
    logic [31:0] r_dvsr;

    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        if (r_sqrt) begin
            lhs = r_rem;
            rhs = r_res + r_bit;
        end else begin
            lhs = {31'd0, r_res[31:0], r_rem[63]};
            rhs = {32'd0, r_dvsr};
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = !diff[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // pulse after the last iteration
            r_done <= r_busy && !i_req.start && (r_cnt == 6'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.sqrt_mode;
                r_dvsr <= i_dvsr;
                r_rem  <= i_opnd;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_cnt  <= i_req.sqrt_mode ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (ge) begin
                        r_rem <= diff[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_res <= ge ? diff[63:0] : lhs;
                    r_rem <= {r_rem[62:0], ge};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_sqrt ? r_res : r_rem;

endmodule

[rtl/projectile_slot_pool.sv]
// Projectile slot pool: spawn, Euler update and interpolated sample of Q16.16 slots.
//
// Input stream s_axis: tuser carries the command (spawn, update, sample, no-op),
// tdata the spawn position and direction, the update step, the slot to sample and
// the interpolation amount. Each input transaction yields exactly one result
// transaction on m_axis with the accept flag, slot, active count, slot state and
// the sampled position.
// One item is worked at a time; s_axis_tready is high only while the sequencer is
// idle. The sequencer steps each item through one shared multiplier and one
// bit-serial root/divide unit; an update walks every slot, and a spawn searches for
// the lowest free slot and, if it finds one, takes a root and two divides.
// Slot data sits in one SLOTS-deep memory read through a registered port.
// The result sits in an output register; a stalled receiver holds it and the next
// item is still taken, finishing only once the register frees up.
// Reset (synchronous, active low) clears every active flag and the count and sets
// speed and lifetime to 1.0; stored slot data is left as is. Speed and lifetime are
// written through the cfg port; the user must do so only while the block is idle,
// and the block itself does not enforce it.
module projectile_slot_pool #(
    parameter int SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [30:0]                 i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_x, pos_y, dir_x, dir_y, step_time, slot_index, amount, zero pad
    input  logic [psp_pkg::IN_W-1:0]    s_axis_tdata,
    // command
    input  logic [psp_pkg::USER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // accepted, slot, active_count, slot_active, out_x, out_y, zero pad
    output logic [psp_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_CHK, ST_FIND, ST_RTS, ST_RTW,
        ST_MULX, ST_DXS, ST_DXW, ST_MULY, ST_DYS, ST_DYW, ST_SPWR,
        ST_UPRD, ST_UPMX, ST_UPMY, ST_UPWR,
        ST_SMRD, ST_SMMX, ST_SMMY, ST_SMFIN, ST_EMIT
    } t_state;

    t_state                r_state;
    logic [SLOTS-1:0]      r_act;
    logic [CW-1:0]         r_cnt;
    logic [AW-1:0]         r_idx;
    logic [30:0]           r_speed;
    logic [30:0]           r_life;

    logic signed [31:0]    r_px, r_py, r_dx, r_dy;
    logic [30:0]           r_st;
    logic [16:0]           r_amt;
    logic                  r_sel_ok;
    logic [63:0]           r_sq;
    logic [31:0]           r_len;
    logic                  r_neg;
    logic signed [31:0]    r_vx, r_vy, r_nx;
    logic signed [65:0]    r_prod;

    logic                  r_acc;
    logic [5:0]            r_slot;
    logic                  r_sact;
    logic signed [31:0]    r_x, r_y;

    logic                  r_ov;
    logic                  r_o_acc;
    logic [5:0]            r_o_slot;
    logic [6:0]            r_o_cnt;
    logic                  r_o_sact;
    logic [31:0]           r_o_x, r_o_y;

    psp_pkg::t_slot        r_mem [SLOTS];
    psp_pkg::t_slot        r_rd;
    psp_pkg::t_slot        wr_data;
    logic                  mem_we;

    psp_pkg::t_unit_req    unit_req;
    logic [63:0]           unit_opnd;
    logic                  unit_done;
    logic [63:0]           unit_res;

    logic signed [32:0]    mul_a, mul_b;
    logic [16:0]           in_amt;
    logic signed [32:0]    life_dec;
    logic                  freed;
    logic signed [31:0]    vel_sat;
    logic signed [31:0]    step_val;
    logic [6:0]            cnt_out;

    assign in_amt = s_axis_tdata[181:165];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQX: begin
                mul_a = 33'(r_dx);
                mul_b = 33'(r_dx);
            end
            ST_SQY: begin
                mul_a = 33'(r_dy);
                mul_b = 33'(r_dy);
            end
            ST_MULX: begin
                mul_a = 33'(r_dx);
                mul_b = $signed({2'b00, r_speed});
            end
            ST_MULY: begin
                mul_a = 33'(r_dy);
                mul_b = $signed({2'b00, r_speed});
            end
            ST_UPMX: begin
                mul_a = 33'(r_rd.vel_x);
                mul_b = $signed({2'b00, r_st});
            end
            ST_UPMY: begin
                mul_a = 33'(r_rd.vel_y);
                mul_b = $signed({2'b00, r_st});
            end
            ST_SMMX: begin
                mul_a = 33'(r_rd.cur_x) - 33'(r_rd.prev_x);
                mul_b = $signed({16'd0, r_amt});
            end
            ST_SMMY: begin
                mul_a = 33'(r_rd.cur_y) - 33'(r_rd.prev_y);
                mul_b = $signed({16'd0, r_amt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // root / divide unit
    always_comb begin
        unit_req.start     = (r_state == ST_RTS) || (r_state == ST_DXS) || (r_state == ST_DYS);
        unit_req.sqrt_mode = (r_state == ST_RTS);
        if (r_state == ST_RTS) begin
            unit_opnd = r_sq;
        end else begin
            unit_opnd = r_prod[65] ? 64'(-r_prod) : 64'(r_prod);
        end
    end

    psp_rootdiv u_rootdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .i_opnd   (unit_opnd),
        .i_dvsr   (r_len),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    // quotient magnitude back to a saturated signed velocity
    always_comb begin
        if (r_neg) begin
            vel_sat = (unit_res > 64'h8000_0000) ? 32'sh80000000 : -$signed(unit_res[31:0]);
        end else begin
            vel_sat = (unit_res > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : $signed(unit_res[31:0]);
        end
    end

    assign life_dec = 33'(r_rd.life) - $signed({2'b00, r_st});
    assign freed    = life_dec[32] || (life_dec == 33'sd0);
    assign step_val = (r_state == ST_UPWR) ?
        psp_pkg::sat32(50'(r_rd.cur_y) + psp_pkg::shr16_tz(r_prod)) :
        psp_pkg::sat32(50'(r_rd.cur_x) + psp_pkg::shr16_tz(r_prod));

    // slot memory write data
    always_comb begin
        mem_we = (r_state == ST_SPWR) || (r_state == ST_UPWR);
        if (r_state == ST_SPWR) begin
            wr_data.cur_x  = r_px;
            wr_data.cur_y  = r_py;
            wr_data.prev_x = r_px;
            wr_data.prev_y = r_py;
            wr_data.vel_x  = r_vx;
            wr_data.vel_y  = r_vy;
            wr_data.life   = $signed({1'b0, r_life});
        end else begin
            wr_data.cur_x  = r_nx;
            wr_data.cur_y  = step_val;
            wr_data.prev_x = r_rd.cur_x;
            wr_data.prev_y = r_rd.cur_y;
            wr_data.vel_x  = r_rd.vel_x;
            wr_data.vel_y  = r_rd.vel_y;
            wr_data.life   = life_dec[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rd <= r_mem[r_idx];
    end

    assign cnt_out = (32'(r_cnt) > 127) ? 7'd127 : 7'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_act   <= '0;
            r_cnt   <= '0;
            r_speed <= psp_pkg::RST_ONE;
            r_life  <= psp_pkg::RST_ONE;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == psp_pkg::CFG_SPEED) begin
                    r_speed <= i_cfg_data;
                end else begin
                    r_life <= i_cfg_data;
                end
            end
            // ST_EMIT loads the register itself
            if (r_ov && m_axis_tready && r_state != ST_EMIT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_px     <= s_axis_tdata[31:0];
                        r_py     <= s_axis_tdata[63:32];
                        r_dx     <= s_axis_tdata[95:64];
                        r_dy     <= s_axis_tdata[127:96];
                        r_st     <= s_axis_tdata[158:128];
                        r_amt    <= (in_amt > psp_pkg::AMT_ONE) ? psp_pkg::AMT_ONE : in_amt;
                        r_acc    <= (s_axis_tuser == psp_pkg::CMD_UPDATE) ||
                                    (s_axis_tuser == psp_pkg::CMD_SAMPLE);
                        r_slot   <= (s_axis_tuser == psp_pkg::CMD_SAMPLE) ?
                                    s_axis_tdata[164:159] : '0;
                        r_sact   <= 1'b0;
                        r_x      <= '0;
                        r_y      <= '0;
                        r_idx    <= (s_axis_tuser == psp_pkg::CMD_SAMPLE) ?
                                    AW'(s_axis_tdata[164:159]) : '0;
                        case (s_axis_tuser)
                            psp_pkg::CMD_SPAWN:  r_state <= ST_SQX;
                            psp_pkg::CMD_UPDATE: r_state <= ST_UPRD;
                            psp_pkg::CMD_SAMPLE: begin
                                r_sel_ok <= 32'(s_axis_tdata[164:159]) < SLOTS;
                                r_state  <= ST_SMRD;
                            end
                            default: r_state <= ST_EMIT;
                        endcase
                    end
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_sq    <= r_prod[63:0];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sq    <= r_sq + r_prod[63:0];
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_sq > psp_pkg::MIN_LEN_SQ && r_speed != '0 && r_life != '0) begin
                        r_state <= ST_FIND;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                // lowest free slot, one per cycle
                ST_FIND: begin
                    if (!r_act[r_idx]) begin
                        r_state <= ST_RTS;
                    end else if (r_idx == LAST) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_RTS: r_state <= ST_RTW;
                ST_RTW: begin
                    if (unit_done) begin
                        r_len   <= unit_res[31:0];
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: r_state <= ST_DXS;
                ST_DXS: begin
                    r_neg   <= r_prod[65];
                    r_state <= ST_DXW;
                end
                ST_DXW: begin
                    if (unit_done) begin
                        r_vx    <= vel_sat;
                        r_state <= ST_MULY;
                    end
                end
                ST_MULY: r_state <= ST_DYS;
                ST_DYS: begin
                    r_neg   <= r_prod[65];
                    r_state <= ST_DYW;
                end
                ST_DYW: begin
                    if (unit_done) begin
                        r_vy    <= vel_sat;
                        r_state <= ST_SPWR;
                    end
                end
                ST_SPWR: begin
                    r_act[r_idx] <= 1'b1;
                    r_cnt        <= r_cnt + CW'(1);
                    r_acc        <= 1'b1;
                    r_slot       <= 6'(r_idx);
                    r_state      <= ST_EMIT;
                end
                ST_UPRD: begin
                    if (r_act[r_idx]) begin
                        r_state <= ST_UPMX;
                    end else if (r_idx == LAST) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_UPMX: r_state <= ST_UPMY;
                ST_UPMY: begin
                    r_nx    <= step_val;
                    r_state <= ST_UPWR;
                end
                ST_UPWR: begin
                    if (freed) begin
                        r_act[r_idx] <= 1'b0;
                        r_cnt        <= r_cnt - CW'(1);
                    end
                    if (r_idx == LAST) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= ST_UPRD;
                    end
                end
                ST_SMRD: r_state <= ST_SMMX;
                ST_SMMX: r_state <= ST_SMMY;
                ST_SMMY: begin
                    if (r_sel_ok) begin
                        r_x <= psp_pkg::sat32(50'(r_rd.prev_x) + psp_pkg::shr16_tz(r_prod));
                    end
                    r_state <= ST_SMFIN;
                end
                ST_SMFIN: begin
                    if (r_sel_ok) begin
                        r_y    <= psp_pkg::sat32(50'(r_rd.prev_y) + psp_pkg::shr16_tz(r_prod));
                        r_sact <= r_act[r_idx];
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov     <= 1'b1;
                        r_o_acc  <= r_acc;
                        r_o_slot <= r_slot;
                        r_o_cnt  <= cnt_out;
                        r_o_sact <= r_sact;
                        r_o_x    <= r_x;
                        r_o_y    <= r_y;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_o_y, r_o_x, r_o_sact, r_o_cnt, r_o_slot, r_o_acc};

endmodule

[rtl/psp_checker.sv]
// Port-level checks for the projectile slot pool, bound to the top level.
`include "assert_macros.svh"

module psp_checker #(
    parameter int SLOTS = 64
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [psp_pkg::OUT_W-1:0]  m_axis_tdata
);

    // a stalled result stays put
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `ASSERT_ANY(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // every accepted item takes the sequencer out of idle, so ready drops
    `ASSERT_RST(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after a transaction")

    `ASSERT_RST(a_cnt_bound, i_clk, i_rst_n, m_axis_tvalid |-> 32'(m_axis_tdata[13:7]) <= SLOTS, "active count beyond pool size")

endmodule

bind projectile_slot_pool psp_checker #(.SLOTS(SLOTS)) u_psp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/projectile_slot_pool_checker.sv]
// Checker for the projectile slot pool: tracks slot state, predicts and compares results.
module projectile_slot_pool_checker #(
    parameter int SLOTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [30:0]                i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [psp_pkg::IN_W-1:0]   i_in_data,
    input  logic [psp_pkg::USER_W-1:0] i_in_user,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [psp_pkg::OUT_W-1:0]  i_out_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_spawned,
    output int                         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] oy;
        logic signed [31:0] ox;
        logic               sact;
        logic [6:0]         cnt;
        logic [5:0]         slot;
        logic               acc;
    } t_pool_result;

    logic [30:0] speed_q, life_q;
    logic        live [SLOTS];
    longint      px [SLOTS], py [SLOTS], cx [SLOTS], cy [SLOTS];
    longint      vx [SLOTS], vy [SLOTS], lf [SLOTS];
    t_pool_result expected_results [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_pool_result advance_pool(input logic [psp_pkg::IN_W-1:0] d,
                                                  input psp_pkg::t_cmd c);
        t_pool_result r;
        longint dx, dy, st, amt, len, n;
        longint unsigned sq;
        r = '0;
        dx = longint'($signed(d[95:64]));
        dy = longint'($signed(d[127:96]));
        st = longint'(d[158:128]);
        amt = longint'(d[181:165]);
        if (c == psp_pkg::CMD_SPAWN) begin
            sq = longint'(dx * dx) + longint'(dy * dy);
            if (sq > psp_pkg::MIN_LEN_SQ && speed_q != 0 && life_q != 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!live[i]) begin
                        len = int_sqrt(sq);
                        cx[i] = longint'($signed(d[31:0]));
                        px[i] = cx[i];
                        cy[i] = longint'($signed(d[63:32]));
                        py[i] = cy[i];
                        vx[i] = clamp32(dx * longint'(speed_q) / len);
                        vy[i] = clamp32(dy * longint'(speed_q) / len);
                        lf[i] = longint'(life_q);
                        live[i] = 1'b1;
                        r.acc = 1'b1;
                        r.slot = i[5:0];
                        break;
                    end
                end
            end
        end else if (c == psp_pkg::CMD_UPDATE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (live[i]) begin
                    px[i] = cx[i];
                    py[i] = cy[i];
                    cx[i] = clamp32(cx[i] + vx[i] * st / 65536);
                    cy[i] = clamp32(cy[i] + vy[i] * st / 65536);
                    lf[i] -= st;
                    if (lf[i] <= 0) live[i] = 1'b0;
                end
            end
            r.acc = 1'b1;
        end else if (c == psp_pkg::CMD_SAMPLE) begin
            r.acc = 1'b1;
            r.slot = d[164:159];
            if (amt > 65536) amt = 65536;
            if (d[164:159] < SLOTS) begin
                r.sact = live[d[164:159]];
                r.ox = 32'(clamp32(px[d[164:159]]
                    + (cx[d[164:159]] - px[d[164:159]]) * amt / 65536));
                r.oy = 32'(clamp32(py[d[164:159]]
                    + (cy[d[164:159]] - py[d[164:159]]) * amt / 65536));
            end
        end
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += live[i];
        r.cnt = (n > 127) ? 7'd127 : n[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pool_result got, want;
        if (!i_rst_n) begin
            speed_q <= psp_pkg::RST_ONE;
            life_q <= psp_pkg::RST_ONE;
            for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
            o_spawned <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == psp_pkg::CFG_SPEED) speed_q <= i_cfg_data;
                else life_q <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                want = advance_pool(i_in_data, psp_pkg::t_cmd'(i_in_user));
                if (want.acc && psp_pkg::t_cmd'(i_in_user) == psp_pkg::CMD_SPAWN)
                    o_spawned <= o_spawned + 1;
                expected_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = t_pool_result'(i_out_data[78:0]);
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (got.acc != want.acc)
                            $error("accepted: expected %0d got %0d", want.acc, got.acc);
                        if (got.slot != want.slot)
                            $error("slot: expected %0d got %0d", want.slot, got.slot);
                        if (got.cnt != want.cnt)
                            $error("active_count: expected %0d got %0d", want.cnt, got.cnt);
                        if (got.sact != want.sact)
                            $error("slot_active: expected %0d got %0d", want.sact, got.sact);
                        if (got.ox != want.ox)
                            $error("out_x: expected %0d got %0d", want.ox, got.ox);
                        if (got.oy != want.oy)
                            $error("out_y: expected %0d got %0d", want.oy, got.oy);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();
endmodule

[test/projectile_slot_pool_tb.sv]
// Testbench top for the projectile slot pool: stimulus, configuration and verdict.
module projectile_slot_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int STALL_LIMIT = 20000;

    logic                       i_clk, i_rst_n;
    logic                       cfg_we, cfg_idx;
    logic [30:0]                cfg_data;
    logic                       in_valid, in_ready, out_valid, out_ready;
    logic [psp_pkg::IN_W-1:0]   in_data;
    logic [psp_pkg::USER_W-1:0] in_user;
    logic [psp_pkg::OUT_W-1:0]  out_data;
    int                         fail_count, pending, spawned, results;
    int                         idle_cycles, n_items;
    logic                       written [SLOTS];
    bit                         timed_out;

    projectile_slot_pool #(.SLOTS(SLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
        .s_axis_tdata(in_data), .s_axis_tuser(in_user),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data)
    );

    projectile_slot_pool_checker #(.SLOTS(SLOTS)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_in_user(in_user),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_spawned(spawned), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stall pattern: long ready runs, short and long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else if ($urandom_range(0, 9) < 7) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) == 0);
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input psp_pkg::t_cmd c, input logic signed [31:0] x, y, dx, dy,
                             input logic [31:0] st, idx, amt);
        in_user <= c;
        in_data <= {2'b0, amt[16:0], idx[5:0], st[30:0], dy, dx, y, x};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        n_items++;
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_write(input logic idx, input logic [30:0] v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        cfg_idx <= idx;
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic spawn_rand();
        logic signed [31:0] dx, dy;
        case ($urandom_range(0, 3))
            0: begin dx = $urandom_range(0, 13) - 6; dy = $urandom_range(0, 13) - 6; end
            1: begin dx = $urandom; dy = $urandom; end
            default: begin
                dx = $signed($urandom_range(0, 262143)) - 131072;
                dy = $signed($urandom_range(0, 262143)) - 131072;
            end
        endcase
        send_item(psp_pkg::CMD_SPAWN, $urandom, $urandom, dx, dy, $urandom, $urandom,
                  $urandom);
    endtask

    // only sample slots that have been spawned at some point
    task automatic sample_rand();
        int k;
        logic [5:0] idx;
        for (int i = 0; i < SLOTS; i++)
            if (i_checker.live[i]) written[i] = 1'b1;
        k = 0;
        idx = 6'($urandom);
        while (!written[idx] && k < 200) begin
            idx = 6'($urandom);
            k++;
        end
        if (written[idx])
            send_item(psp_pkg::CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                      32'(idx),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536));
    endtask

    task automatic random_phase(input int count, input int spawn_w);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            case (($urandom_range(0, 99) < spawn_w) ? 0 : $urandom_range(1, 7))
                0, 1: spawn_rand();
                2, 3: send_item(psp_pkg::CMD_UPDATE, $urandom, $urandom, $urandom, $urandom,
                                ($urandom_range(0, 4) == 0) ? $urandom
                                    : $urandom_range(0, 40000),
                                $urandom, $urandom);
                4, 5, 6: sample_rand();
                default: send_item(psp_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        timed_out = 1'b0;
        n_items = 0;
        for (int i = 0; i < SLOTS; i++) written[i] = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = psp_pkg::CFG_SPEED;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        in_user = psp_pkg::CMD_NOP;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, short direction, every command
        send_item(psp_pkg::CMD_SPAWN, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  32'sh80000000, 32'h7FFFFFFF, 32'h3F, 32'h1FFFF);
        send_item(psp_pkg::CMD_SPAWN, 0, 0, 32'sd6, 32'sd3, 0, 0, 0);    // 45: accepted
        send_item(psp_pkg::CMD_SPAWN, 0, 0, 32'sd6, 32'sd2, 0, 0, 0);    // 40: short
        send_item(psp_pkg::CMD_SPAWN, 32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh80000000,
                  0, 0, 0);
        send_item(psp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 65536);
        send_item(psp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 1, 32'h1FFFF);    // amount above one
        send_item(psp_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);            // zero step
        send_item(psp_pkg::CMD_UPDATE, 0, 0, 0, 0, 30000, 0, 0);
        send_item(psp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 2, 0);
        send_item(psp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32768);
        send_item(psp_pkg::CMD_NOP, '1, '1, '1, '1, '1, '1, '1);
        send_item(psp_pkg::CMD_UPDATE, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0); // frees all
        send_item(psp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 65536);        // inactive slot

        drain_and_write(psp_pkg::CFG_SPEED, 31'd0);
        send_item(psp_pkg::CMD_SPAWN, 0, 0, 32'sd65536, 0, 0, 0, 0);    // zero speed
        drain_and_write(psp_pkg::CFG_SPEED, 31'h7FFFFFFF);
        drain_and_write(psp_pkg::CFG_LIFETIME, 31'd0);
        send_item(psp_pkg::CMD_SPAWN, 0, 0, 32'sd65536, 0, 0, 0, 0);    // zero lifetime
        drain_and_write(psp_pkg::CFG_LIFETIME, 31'h7FFFFFFF);
        // fill the pool, then one more spawn finds it full
        for (int i = 0; i < SLOTS + 1; i++)
            send_item(psp_pkg::CMD_SPAWN, $urandom, $urandom, 32'sd7, 32'sd65536, 0, 0, 0);
        random_phase(100, 20);

        drain_and_write(psp_pkg::CFG_SPEED, 31'd65536);
        drain_and_write(psp_pkg::CFG_LIFETIME, 31'd200000);
        random_phase(250, 40);
        drain_and_write(psp_pkg::CFG_SPEED, 31'($urandom));
        drain_and_write(psp_pkg::CFG_LIFETIME, 31'($urandom_range(1, 1000000)));
        random_phase(250, 35);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("run: %0d items, %0d results, %0d accepted spawns, configs at extremes",
                 n_items, results, spawned);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_rootdiv.sv
rtl/projectile_slot_pool.sv
rtl/psp_checker.sv
test/projectile_slot_pool_checker.sv
test/projectile_slot_pool_tb.sv
